>>> design/mipd_pkg.sv
// Package: opcode match table, field codes and shared types for the MIPS predecoder.
`default_nettype none
package mipd_pkg;

  localparam int TABLE_ENTRIES = 229;
  localparam int ADDR_WIDTH    = 32;
  localparam int IDX_W         = 8;

  typedef enum logic [1:0] {
    TK_NONE = 2'd0,
    TK_B16  = 2'd1,
    TK_B21  = 2'd2,
    TK_JMP  = 2'd3
  } tk_e;

  typedef enum logic [1:0] {
    FK_NONE   = 2'd0,
    FK_BRANCH = 2'd1,
    FK_MOVE   = 2'd2
  } fk_e;

  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] value;
    logic        upi;
    tk_e         kind;
  } row_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             upi;
    tk_e              kind;
  } match_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] word;
    logic [31:0] addr;
  } prev_t;

  localparam logic [5:0]  OPC_JIC        = 6'h36;
  localparam logic [5:0]  OPC_DADDIU     = 6'h19;
  localparam logic [31:0] AUIPC_MASK     = 32'hFC1F0000;
  localparam logic [31:0] AUIPC_VALUE    = 32'hEC1E0000;

  localparam int unsigned RTM = 32'hFC00003F;
  localparam int unsigned ITM = 32'hFC000000;
  localparam int unsigned M6  = 32'hFC0007FF;
  localparam int unsigned MRT = 32'hFC1F0000;
  localparam int unsigned MRS = 32'hFFE00000;
  localparam int unsigned FPR = 32'hFFE0003F;
  localparam int unsigned FPA = 32'hFE00003F;
  localparam int unsigned FPU = 32'hFE1F003F;

  function automatic int unsigned op(int unsigned o);
    return o << 26;
  endfunction

  function automatic row_t mk(int unsigned m, int unsigned v, tk_e k);
    row_t r;
    r.mask  = 32'(m);
    r.value = 32'(v);
    r.upi   = 1'b0;
    r.kind  = k;
    return r;
  endfunction

  function automatic row_t mku(int unsigned m, int unsigned v);
    row_t r;
    r.mask  = 32'(m);
    r.value = 32'(v);
    r.upi   = 1'b1;
    r.kind  = TK_NONE;
    return r;
  endfunction

  function automatic row_t dg(int unsigned o, int unsigned k);
    return mk(ITM | 32'h03FF0000, op(o) | (k << 21) | (k << 16), TK_B16);
  endfunction

  localparam int unsigned C1  = 32'h44000000;
  localparam int unsigned C1S = 32'h46000000;

  localparam row_t MATCH_TABLE [TABLE_ENTRIES] = '{
    mk(32'hFFFFFFFF, 0, TK_NONE),
    mk(RTM, 0, TK_NONE), mk(RTM, 2, TK_NONE), mk(RTM, 3, TK_NONE), mk(RTM, 4, TK_NONE),
    mk(RTM, 6, TK_NONE), mk(RTM, 7, TK_NONE),
    mk(RTM, 8, TK_NONE), mk(RTM | 32'hF800, 9 | (31 << 11), TK_NONE),
    mk(RTM | 32'hF800, 9, TK_NONE), mk(RTM, 9, TK_NONE),
    mk(M6, 10, TK_NONE), mk(M6, 11, TK_NONE), mk(RTM, 12, TK_NONE), mk(RTM, 13, TK_NONE),
    mk(RTM, 15, TK_NONE),
    mk(RTM, 16, TK_NONE), mk(RTM, 17, TK_NONE), mk(RTM, 18, TK_NONE), mk(RTM, 19, TK_NONE),
    mk(RTM, 20, TK_NONE), mk(RTM, 22, TK_NONE), mk(RTM, 23, TK_NONE),
    mk(M6, 24, TK_NONE), mk(M6, 25, TK_NONE), mk(M6, 26, TK_NONE), mk(M6, 27, TK_NONE),
    mk(M6, 24 + (2 << 6), TK_NONE), mk(M6, 24 + (3 << 6), TK_NONE),
    mk(M6, 26 + (2 << 6), TK_NONE), mk(M6, 26 + (3 << 6), TK_NONE),
    mk(RTM, 32, TK_NONE), mk(RTM, 33, TK_NONE), mk(RTM, 34, TK_NONE), mk(RTM, 35, TK_NONE),
    mk(RTM, 36, TK_NONE), mk(RTM, 37, TK_NONE),
    mk(RTM, 38, TK_NONE), mk(RTM, 39, TK_NONE), mk(RTM, 42, TK_NONE), mk(RTM, 43, TK_NONE),
    mk(RTM, 45, TK_NONE), mk(RTM, 46, TK_NONE),
    mk(RTM, 47, TK_NONE), mk(RTM, 56, TK_NONE), mk(RTM, 58, TK_NONE), mk(RTM, 59, TK_NONE),
    mk(RTM, 60, TK_NONE),
    mk(RTM | 32'h03E00000, 62 | (1 << 21), TK_NONE), mk(RTM, 62, TK_NONE),
    mk(RTM, 63, TK_NONE),
    mk(RTM, op(31) | 3, TK_NONE),
    mk(RTM | 32'h03E00000 | 32'h7C0, op(31) | (16 << 6) | 32, TK_NONE),
    mk(RTM | 32'h03E00000 | 32'h7C0, op(31) | (24 << 6) | 32, TK_NONE),
    mk(M6, (2 << 6) | 24, TK_NONE), mk(M6, (3 << 6) | 24, TK_NONE),
    mk(M6, (2 << 6) | 25, TK_NONE), mk(M6, (3 << 6) | 25, TK_NONE),
    mk(M6, (2 << 6) | 26, TK_NONE), mk(M6, (3 << 6) | 26, TK_NONE),
    mk(M6, (2 << 6) | 27, TK_NONE), mk(M6, (3 << 6) | 27, TK_NONE),
    mk(M6, (2 << 6) | 28, TK_NONE), mk(M6, (3 << 6) | 28, TK_NONE),
    mk(M6, (2 << 6) | 29, TK_NONE), mk(M6, (3 << 6) | 29, TK_NONE),
    mk(M6, (2 << 6) | 30, TK_NONE), mk(M6, (3 << 6) | 30, TK_NONE),
    mk(M6, (2 << 6) | 31, TK_NONE), mk(M6, (3 << 6) | 31, TK_NONE),
    mk(M6, op(28) | 2, TK_NONE), mk(M6, op(28) | 32, TK_NONE),
    mk(32'hFC00FFFF, op(28) | 0, TK_NONE), mk(32'hFC00FFFF, op(28) | 1, TK_NONE),
    mk(32'hFC00FFFF, op(28) | 2, TK_NONE),
    mk(32'hFC00FFFF, op(28) | 4, TK_NONE), mk(32'hFC00FFFF, op(28) | 5, TK_NONE),
    mk(RTM, op(28) | 32'h3F, TK_NONE),
    mk(ITM, op(2), TK_JMP), mk(ITM, op(3), TK_JMP),
    mk(ITM, op(4), TK_B16), mk(ITM, op(5), TK_B16),
    mk(MRT, op(1) | (1 << 16), TK_B16), mk(MRT, op(1), TK_B16),
    mk(MRT, op(1) | (2 << 16), TK_B16),
    mk(MRT, op(1) | (16 << 16), TK_B16), mk(MRT, op(1) | (18 << 16), TK_B16),
    mk(MRT, op(6), TK_B16), mk(ITM, op(6), TK_B16), mk(MRT, op(7), TK_B16),
    mk(ITM, op(7), TK_B16),
    mk(MRT, op(1) | (6 << 16), TK_NONE), mk(MRT, op(1) | (30 << 16), TK_NONE),
    mk(32'hFFFF0000, op(4), TK_B16), mk(32'hFFFF0000, op(1) | (17 << 16), TK_B16),
    mk(ITM, op(8), TK_B16),
    mk(ITM, op(8), TK_NONE), mk(ITM, op(9), TK_NONE), mk(ITM, op(10), TK_NONE),
    mk(ITM, op(11), TK_NONE),
    mk(ITM, op(12), TK_NONE), mk(ITM, op(13), TK_NONE), mk(ITM, op(14), TK_NONE),
    mku(MRS, op(15)), mku(ITM, op(15)),
    mk(MRS, op(22), TK_B16),
    dg(22, 1), dg(22, 2), dg(22, 3), dg(22, 4), dg(22, 5), dg(22, 6), dg(22, 7), dg(22, 8),
    dg(22, 9), dg(22, 10), dg(22, 11), dg(22, 12), dg(22, 13), dg(22, 14), dg(22, 15),
    dg(22, 16), dg(22, 17), dg(22, 18), dg(22, 19), dg(22, 20), dg(22, 21), dg(22, 22),
    dg(22, 23), dg(22, 24), dg(22, 25), dg(22, 26), dg(22, 27), dg(22, 28), dg(22, 29),
    dg(22, 30), dg(22, 31),
    mk(ITM, op(22), TK_B16),
    mk(MRS, op(23), TK_B16),
    dg(23, 1), dg(23, 2), dg(23, 3), dg(23, 4), dg(23, 5), dg(23, 6), dg(23, 7), dg(23, 8),
    dg(23, 9), dg(23, 10), dg(23, 11), dg(23, 12), dg(23, 13), dg(23, 14), dg(23, 15),
    dg(23, 16), dg(23, 17), dg(23, 18), dg(23, 19), dg(23, 20), dg(23, 21), dg(23, 22),
    dg(23, 23), dg(23, 24), dg(23, 25), dg(23, 26), dg(23, 27), dg(23, 28), dg(23, 29),
    dg(23, 30), dg(23, 31),
    mk(ITM, op(23), TK_B16), mk(ITM, op(24), TK_B16),
    mk(ITM, op(25), TK_NONE), mk(ITM, op(29), TK_NONE),
    mk(ITM, op(32), TK_NONE), mk(ITM, op(33), TK_NONE), mk(ITM, op(35), TK_NONE),
    mk(ITM, op(36), TK_NONE),
    mk(ITM, op(37), TK_NONE), mk(ITM, op(39), TK_NONE), mk(ITM, op(40), TK_NONE),
    mk(ITM, op(41), TK_NONE),
    mk(ITM, op(43), TK_NONE), mk(ITM, op(49), TK_NONE), mk(ITM, op(53), TK_NONE),
    mk(MRS, op(54), TK_NONE),
    mk(ITM | (1 << 21), op(54) | (1 << 21), TK_B21),
    mk(ITM | (1 << 22), op(54) | (1 << 22), TK_B21),
    mk(ITM | (1 << 23), op(54) | (1 << 23), TK_B21),
    mk(ITM | (1 << 24), op(54) | (1 << 24), TK_B21),
    mk(ITM | (1 << 25), op(54) | (1 << 25), TK_B21),
    mk(ITM, op(55), TK_NONE), mk(ITM, op(57), TK_NONE),
    mk(MRT, op(59) | (30 << 16), TK_NONE), mk(ITM, op(61), TK_NONE),
    mk(MRS, op(62), TK_NONE),
    mk(ITM | (1 << 21), op(62) | (1 << 21), TK_B21),
    mk(ITM | (1 << 22), op(62) | (1 << 22), TK_B21),
    mk(ITM | (1 << 23), op(62) | (1 << 23), TK_B21),
    mk(ITM | (1 << 24), op(62) | (1 << 24), TK_B21),
    mk(ITM | (1 << 25), op(62) | (1 << 25), TK_B21),
    mk(ITM, op(63), TK_NONE),
    mk(FPR, C1 | (0 << 21), TK_NONE), mk(FPR, C1 | (1 << 21), TK_NONE),
    mk(FPR, C1 | (3 << 21), TK_NONE),
    mk(FPR, C1 | (4 << 21), TK_NONE), mk(FPR, C1 | (5 << 21), TK_NONE),
    mk(FPR, C1 | (7 << 21), TK_NONE),
    mk(FPA, C1 | (32'h10 << 21) | 0, TK_NONE), mk(FPA, C1 | (32'h10 << 21) | 1, TK_NONE),
    mk(FPA, C1 | (32'h10 << 21) | 2, TK_NONE),
    mk(FPA, C1 | (32'h10 << 21) | 3, TK_NONE), mk(FPA, C1 | (32'h10 << 21) | 4, TK_NONE),
    mk(FPU, C1S | 5, TK_NONE), mk(FPU, C1S | 6, TK_NONE), mk(FPU, C1S | 7, TK_NONE),
    mk(FPU, C1S | 8, TK_NONE), mk(FPU, C1S | 9, TK_NONE), mk(FPU, C1S | 10, TK_NONE),
    mk(FPU, C1S | 11, TK_NONE), mk(FPU, C1S | 12, TK_NONE), mk(FPU, C1S | 13, TK_NONE),
    mk(FPU, C1S | 14, TK_NONE), mk(FPU, C1S | 15, TK_NONE),
    mk(FPU, C1S | 32, TK_NONE), mk(FPU, C1S | 33, TK_NONE), mk(FPU, C1S | 36, TK_NONE),
    mk(FPU, C1S | 37, TK_NONE), mk(FPU, C1S | 38, TK_NONE)
  };

  function automatic logic [2:0] fmt_code(logic [2:0] f);
    logic [2:0] c;
    case (f)
      3'd0:    c = 3'd0;
      3'd1:    c = 3'd1;
      3'd4:    c = 3'd2;
      3'd5:    c = 3'd3;
      3'd6:    c = 3'd4;
      default: c = 3'd5;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> design/mipd_match.sv
// Priority match of one instruction word against the opcode table.
`default_nettype none
module mipd_match (
  input  wire logic [31:0]     word_i,
  output mipd_pkg::match_t     match_o
);

  always_comb begin
    match_o.idx  = mipd_pkg::IDX_W'(mipd_pkg::TABLE_ENTRIES);
    match_o.upi  = 1'b0;
    match_o.kind = mipd_pkg::TK_NONE;
    // Scan from the back so the lowest hit wins.
    for (int i = mipd_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if ((word_i & mipd_pkg::MATCH_TABLE[i].mask) == mipd_pkg::MATCH_TABLE[i].value) begin
        match_o.idx  = mipd_pkg::IDX_W'(i);
        match_o.upi  = mipd_pkg::MATCH_TABLE[i].upi;
        match_o.kind = mipd_pkg::MATCH_TABLE[i].kind;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/mipd_target.sv
// Immediate, branch target and auipc pair fusion for one instruction.
`default_nettype none
module mipd_target (
  input  wire logic [31:0]     word_i,
  input  wire logic [31:0]     addr_i,
  input  wire mipd_pkg::match_t match_i,
  input  wire mipd_pkg::prev_t  prev_i,
  output logic      [31:0]     imm_o,
  output logic      [31:0]     target_o,
  output mipd_pkg::fk_e        fused_kind_o,
  output logic      [31:0]     fused_target_o
);

  logic [4:0]  rs, rt;
  logic [5:0]  opc;
  logic [31:0] addr4, off, comb_off;
  logic        is_jic, is_daddiu, pair_ok;

  assign rs    = word_i[25:21];
  assign rt    = word_i[20:16];
  assign opc   = word_i[31:26];
  assign addr4 = addr_i + 32'd4;

  assign imm_o = match_i.upi ? {word_i[15:0], 16'h0000} : {{16{word_i[15]}}, word_i[15:0]};

  always_comb begin
    case (match_i.kind)
      mipd_pkg::TK_B16: target_o = addr4 + {{14{word_i[15]}}, word_i[15:0], 2'b00};
      mipd_pkg::TK_B21: target_o = addr4 + {{9{word_i[20]}}, word_i[20:0], 2'b00};
      mipd_pkg::TK_JMP: target_o = {addr4[31:28], word_i[25:0], 2'b00};
      default:          target_o = 32'h0;
    endcase
  end

  assign is_jic    = (opc == mipd_pkg::OPC_JIC) && (rs == 5'd0) && (rt != 5'd0);
  assign is_daddiu = (opc == mipd_pkg::OPC_DADDIU) && (rs == rt) && (rt != 5'd0);
  assign pair_ok   = prev_i.valid && ((addr_i - prev_i.addr) == 32'd4) &&
                     ((prev_i.word & mipd_pkg::AUIPC_MASK) == mipd_pkg::AUIPC_VALUE) &&
                     (prev_i.word[25:21] == rt);

  // Low half is signed, so borrow one from the upper half when it is negative.
  assign comb_off = {prev_i.word[15:0], word_i[15:0]};
  assign off      = comb_off - (word_i[15] ? 32'h0001_0000 : 32'h0) - 32'd4;

  always_comb begin
    fused_kind_o   = mipd_pkg::FK_NONE;
    fused_target_o = 32'h0;
    if (pair_ok && (is_jic || is_daddiu)) begin
      fused_kind_o   = is_jic ? mipd_pkg::FK_BRANCH : mipd_pkg::FK_MOVE;
      fused_target_o = addr_i + off;
    end
  end

endmodule
`default_nettype wire

>>> design/mips_instruction_predecoder.sv
// Top level of the MIPS instruction predecoder: input stage, decode, result stage.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_ready_o | instr_word_i, instr_addr_i
//  out     | output    | out_valid_o / out_ready_i | entry_index_o ... fused_target_o
//
// An accepted beat is held in the input register; when the result stage can take it,
// table match and target adds run into the result register, which drives out_valid_o.
// One beat is taken per cycle while the result stage is not stalled.
// Reset clears both stage valids and the previous-instruction record.
// A stalled result holds; an empty input stage still fills while the result waits.
`default_nettype none
module mips_instruction_predecoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] instr_word_i,
  input  wire logic [31:0] instr_addr_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       entry_index_o,
  output logic [4:0]       src_reg_o,
  output logic [4:0]       tgt_reg_o,
  output logic [4:0]       dst_reg_o,
  output logic [4:0]       shift_amount_o,
  output logic [2:0]       fp_format_o,
  output logic [31:0]      immediate_value_o,
  output logic [1:0]       target_kind_o,
  output logic [31:0]      branch_target_o,
  output logic [1:0]       fused_kind_o,
  output logic [31:0]      fused_target_o
);

  // Input stage.
  logic        s0_valid_q;
  logic [31:0] s0_word_q, s0_addr_q;

  // Previous instruction, updated as each beat leaves the decode stage.
  mipd_pkg::prev_t prev_q, prev_d;

  // Result stage.
  logic        out_valid_q;
  logic [7:0]  idx_q;
  logic [2:0]  fmt_q;
  logic [31:0] word_q, imm_q, tgt_q, ftgt_q;
  mipd_pkg::tk_e kind_q;
  mipd_pkg::fk_e fkind_q;

  logic s1_ready, advance;

  mipd_pkg::match_t match;
  logic [31:0]      imm, tgt, ftgt;
  mipd_pkg::fk_e    fkind;

  assign s1_ready   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s0_valid_q || s1_ready;
  assign advance    = s0_valid_q && s1_ready;

  mipd_match u_match (
    .word_i  (s0_word_q),
    .match_o (match)
  );

  mipd_target u_target (
    .word_i         (s0_word_q),
    .addr_i         (s0_addr_q),
    .match_i        (match),
    .prev_i         (prev_q),
    .imm_o          (imm),
    .target_o       (tgt),
    .fused_kind_o   (fkind),
    .fused_target_o (ftgt)
  );

  always_comb begin
    prev_d = prev_q;
    if (advance) begin
      prev_d.valid = 1'b1;
      prev_d.word  = s0_word_q;
      prev_d.addr  = s0_addr_q;
    end
  end

  // Hold control state under reset; payload registers load without it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
    end else begin
      if (in_ready_o) begin
        s0_valid_q <= in_valid_i;
      end
      if (s1_ready) begin
        out_valid_q <= s0_valid_q;
      end
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s0_word_q <= instr_word_i;
      s0_addr_q <= instr_addr_i;
    end
    if (advance) begin
      idx_q   <= match.idx;
      word_q  <= s0_word_q;
      fmt_q   <= mipd_pkg::fmt_code(s0_word_q[23:21]);
      imm_q   <= imm;
      kind_q  <= match.kind;
      tgt_q   <= tgt;
      fkind_q <= fkind;
      ftgt_q  <= ftgt;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign entry_index_o     = idx_q;
  assign src_reg_o         = word_q[25:21];
  assign tgt_reg_o         = word_q[20:16];
  assign dst_reg_o         = word_q[15:11];
  assign shift_amount_o    = word_q[10:6];
  assign fp_format_o       = fmt_q;
  assign immediate_value_o = imm_q;
  assign target_kind_o     = kind_q;
  assign branch_target_o   = tgt_q;
  assign fused_kind_o      = fkind_q;
  assign fused_target_o    = ftgt_q;

`ifndef NO_ASSERTIONS
  a_no_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (target_kind_o == mipd_pkg::TK_NONE) |-> branch_target_o == 32'h0)
    else $error("branch target set without a target kind");

  a_no_fused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fused_kind_o == mipd_pkg::FK_NONE) |-> fused_target_o == 32'h0)
    else $error("fused target set without a pair");

  a_miss_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (entry_index_o == 8'(mipd_pkg::TABLE_ENTRIES))
      |-> target_kind_o == mipd_pkg::TK_NONE)
    else $error("unmatched word carries a target kind");

  a_prev_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> prev_q.valid && (prev_q.word == word_q))
    else $error("previous word not recorded on advance");
`endif

endmodule
`default_nettype wire
